// ----- rtl/round_robin_tick_scheduler_defines.svh -----
// assertion macros for the tick scheduler
`ifndef ROUND_ROBIN_TICK_SCHEDULER_DEFINES_SVH
`define ROUND_ROBIN_TICK_SCHEDULER_DEFINES_SVH
`ifndef SYNTHESIS
`define RRTS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define RRTS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define RRTS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RRTS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/rrts_pkg.sv -----
package rrts_pkg;

  localparam int OP_BITS = 2;
  localparam logic [OP_BITS-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_BITS-1:0] OP_TICK   = 2'd1;
  localparam logic [OP_BITS-1:0] OP_CLEAR  = 2'd2;

  typedef enum logic [1:0] {
    ST_WAIT  = 2'd0,
    ST_READY = 2'd1,
    ST_RUN   = 2'd2,
    ST_DONE  = 2'd3
  } status_t;

  localparam logic [7:0] QUANTUM_RESET = 8'd2;

  // sequencer states
  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SCAN1 = 8'b0000_0010,
    S_RUN   = 8'b0000_0100,
    S_PICK0 = 8'b0000_1000,
    S_PICK1 = 8'b0001_0000,
    S_APPLY = 8'b0010_0000,
    S_COUNT = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

endpackage

// ----- rtl/round_robin_tick_scheduler.sv -----
// Round-robin tick scheduler over a table of up to ENTRIES process entries. Each input
// beat is an append, a tick, a clear or an unused code, and gives one result beat. The
// result of an append, a clear or an unused code waits for a walk over the table, which
// forms the unfinished count. A tick walks the table with one shared entry port and one
// compare unit: an admission pass, a running-entry pass, two pick passes, an update
// step and a count pass. The block is not ready while a beat is in work or while its
// result waits in the output register. It is ready for the next beat in the cycle after
// that result is taken.
`include "round_robin_tick_scheduler_defines.svh"
module round_robin_tick_scheduler #(
  parameter int ENTRIES   = 16,
  parameter int TIME_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  // operation[1:0]
  input  logic [1:0]  in_tuser,
  // pid[7:0], arrive_time[23:8], burst_time[39:24]
  input  logic [39:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // cpu_busy[0], running_pid[8:1], finish_valid[9], finish_pid[17:10],
  // turnaround[33:18], waiting[49:34], unfinished_count[54:50], table_full[55]
  output logic [55:0] out_tdata
);
  import rrts_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  // entry table
  logic [7:0]  pid_m     [ENTRIES];
  logic [15:0] arr_m     [ENTRIES];
  logic [15:0] burst_m   [ENTRIES];
  logic [15:0] work_m    [ENTRIES];
  logic [7:0]  slice_m   [ENTRIES];
  status_t     stat_m    [ENTRIES];
  logic        mark_m    [ENTRIES];

  state_t         state_r, state_nxt;
  logic [CW-1:0]  count_r;
  logic [TIME_BITS-1:0] tick_r;
  logic [7:0]     quantum_r;
  logic [CW-1:0]  idx_r;
  logic           disp_r;
  logic           best_v_r;
  logic [IW-1:0]  best_r;
  logic [15:0]    best_arr_r;
  logic           any0_r;
  logic           busy_r, fin_r, full_r;
  logic [7:0]     run_pid_r, fin_pid_r;
  logic [15:0]    ta_r, wt_r;
  logic [CW-1:0]  unfin_r;
  logic [55:0]    out_data_r;
  logic           out_valid_r;

  logic [IW-1:0] ix;
  logic          at_end;
  assign ix     = idx_r[IW-1:0];
  assign at_end = (idx_r == count_r);

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // finish figures for the entry under the pointer
  logic [TIME_BITS-1:0] diff;
  logic [31:0] diff_w;
  logic [15:0] ta_c;
  assign diff   = tick_r - TIME_BITS'(arr_m[ix]);
  assign diff_w = 32'(diff);
  assign ta_c   = (diff_w > 32'h0000_FFFF) ? 16'hFFFF : diff_w[15:0];

  // sequencer state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready)
          state_nxt = (in_tuser == OP_TICK) ? S_SCAN1 : S_COUNT;
      end
      S_SCAN1: if (at_end) state_nxt = S_RUN;
      S_RUN:   if (at_end || stat_m[ix] == ST_RUN) state_nxt = S_PICK0;
      S_PICK0: if (at_end) state_nxt = S_PICK1;
      S_PICK1: if (at_end) state_nxt = S_APPLY;
      S_APPLY: state_nxt = S_COUNT;
      S_COUNT: if (at_end) state_nxt = S_OUT;
      S_OUT:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      tick_r      <= '0;
      quantum_r   <= QUANTUM_RESET;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) quantum_r <= cfg_data;
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          idx_r <= '0;
          if (in_tvalid && in_tready) begin
            disp_r     <= 1'b0;
            busy_r     <= 1'b0;
            fin_r      <= 1'b0;
            full_r     <= 1'b0;
            run_pid_r  <= '0;
            fin_pid_r  <= '0;
            ta_r       <= '0;
            wt_r       <= '0;
            best_v_r   <= 1'b0;
            any0_r     <= 1'b0;
            unfin_r    <= '0;
            // append and clear act at once
            if (in_tuser == OP_APPEND) begin
              if (count_r < CW'(ENTRIES)) begin
                pid_m[count_r[IW-1:0]]   <= in_tdata[7:0];
                arr_m[count_r[IW-1:0]]   <= in_tdata[23:8];
                burst_m[count_r[IW-1:0]] <= in_tdata[39:24];
                work_m[count_r[IW-1:0]]  <= '0;
                slice_m[count_r[IW-1:0]] <= quantum_r;
                stat_m[count_r[IW-1:0]]  <= ST_WAIT;
                mark_m[count_r[IW-1:0]]  <= 1'b0;
                count_r <= count_r + 1'b1;
              end else begin
                full_r <= 1'b1;
              end
            end else if (in_tuser == OP_CLEAR) begin
              count_r <= '0;
              tick_r  <= '0;
            end
          end
        end
        // admission pass
        S_SCAN1: begin
          if (at_end) idx_r <= '0;
          else begin
            if (stat_m[ix] == ST_WAIT && 32'(arr_m[ix]) == 32'(tick_r))
              stat_m[ix] <= ST_READY;
            idx_r <= idx_r + 1'b1;
          end
        end
        // running entry: retire, continue or rotate out
        S_RUN: begin
          if (at_end) idx_r <= '0;
          else if (stat_m[ix] == ST_RUN) begin
            idx_r <= '0;
            if (work_m[ix] >= burst_m[ix]) begin
              stat_m[ix] <= ST_DONE;
              fin_r      <= 1'b1;
              fin_pid_r  <= pid_m[ix];
              ta_r       <= ta_c;
              wt_r       <= (ta_c > burst_m[ix]) ? ta_c - burst_m[ix] : 16'd0;
            end else if (slice_m[ix] != '0) begin
              slice_m[ix] <= slice_m[ix] - 1'b1;
              if (work_m[ix] != 16'hFFFF) work_m[ix] <= work_m[ix] + 1'b1;
              disp_r    <= 1'b1;
              busy_r    <= 1'b1;
              run_pid_r <= pid_m[ix];
            end else begin
              stat_m[ix]  <= ST_READY;
              mark_m[ix]  <= 1'b1;
              slice_m[ix] <= quantum_r;
            end
          end else idx_r <= idx_r + 1'b1;
        end
        // pick among unmarked ready entries
        S_PICK0: begin
          if (at_end) idx_r <= '0;
          else begin
            if (!disp_r && stat_m[ix] == ST_READY && !mark_m[ix] &&
                (!best_v_r || arr_m[ix] < best_arr_r)) begin
              best_v_r   <= 1'b1;
              best_r     <= ix;
              best_arr_r <= arr_m[ix];
              any0_r     <= 1'b1;
            end
            idx_r <= idx_r + 1'b1;
          end
        end
        // fallback pick among marked entries, clearing marks
        S_PICK1: begin
          if (at_end) idx_r <= '0;
          else begin
            if (!disp_r && !any0_r && stat_m[ix] == ST_READY && mark_m[ix]) begin
              mark_m[ix] <= 1'b0;
              if (!best_v_r || arr_m[ix] < best_arr_r) begin
                best_v_r   <= 1'b1;
                best_r     <= ix;
                best_arr_r <= arr_m[ix];
              end
            end
            idx_r <= idx_r + 1'b1;
          end
        end
        S_APPLY: begin
          idx_r <= '0;
          if (!disp_r && best_v_r) begin
            stat_m[best_r] <= ST_RUN;
            if (work_m[best_r] != 16'hFFFF) work_m[best_r] <= work_m[best_r] + 1'b1;
            if (slice_m[best_r] != '0) slice_m[best_r] <= slice_m[best_r] - 1'b1;
            busy_r    <= 1'b1;
            run_pid_r <= pid_m[best_r];
          end
          tick_r <= tick_r + 1'b1;
        end
        S_COUNT: begin
          if (at_end) idx_r <= '0;
          else begin
            if (stat_m[ix] != ST_DONE) unfin_r <= unfin_r + 1'b1;
            idx_r <= idx_r + 1'b1;
          end
        end
        S_OUT: begin
          out_valid_r <= 1'b1;
          out_data_r  <= {full_r, 5'(unfin_r), wt_r, ta_r, fin_pid_r, fin_r,
                          run_pid_r, busy_r};
        end
        default: ;
      endcase
    end
  end

  `RRTS_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, count_r <= CW'(ENTRIES))
  `RRTS_ASSERT_IMP(a_no_accept_busy, clk, rst_n, state_r != S_IDLE, !in_tready)
  `RRTS_ASSERT_NXT(a_out_follows, clk, rst_n, state_r == S_OUT, out_valid_r)
  `RRTS_ASSERT_IMP(a_unfin_bound, clk, rst_n, state_r == S_OUT, unfin_r <= count_r)

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  import rrts_pkg::*;

  localparam int SLOTS = 16;
  localparam longint CYCLE_LIMIT = 2000000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic        table_full;
    logic [4:0]  unfinished_count;
    logic [15:0] waiting;
    logic [15:0] turnaround;
    logic [7:0]  finish_pid;
    logic        finish_valid;
    logic [7:0]  running_pid;
    logic        cpu_busy;
  } sched_report_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data;
  logic        in_tvalid;
  logic        in_tready;
  // operation[1:0]
  logic [1:0]  in_tuser;
  // pid[7:0], arrive_time[23:8], burst_time[39:24]
  logic [39:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  // cpu_busy[0], running_pid[8:1], finish_valid[9], finish_pid[17:10],
  // turnaround[33:18], waiting[49:34], unfinished_count[54:50], table_full[55]
  logic [55:0] out_tdata;

  round_robin_tick_scheduler DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // shadow copy of the scheduler table
  logic [7:0]  sh_pid     [SLOTS];
  logic [15:0] sh_arrival [SLOTS];
  logic [15:0] sh_burst   [SLOTS];
  logic [15:0] sh_work    [SLOTS];
  logic [7:0]  sh_slice   [SLOTS];
  status_t     sh_status  [SLOTS];
  logic        sh_mark    [SLOTS];
  int          sh_count;
  logic [15:0] sh_tick;
  logic [7:0]  sh_quantum;

  sched_report_t report_queue[$];
  int   mismatch_count = 0;
  int   send_idle_pct;
  int   recv_idle_pct;
  longint cycle_count = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // earliest-arriving ready entry with a given round mark, -1 if none
  function automatic int find_ready(logic mark);
    int best;
    best = -1;
    for (int i = 0; i < sh_count; i++)
      if (sh_status[i] == ST_READY && sh_mark[i] == mark)
        if (best < 0 || sh_arrival[i] < sh_arrival[best]) best = i;
    return best;
  endfunction

  // advance the shadow table by one beat and return the expected report
  function automatic sched_report_t schedule_step(logic [41:0] beat);
    sched_report_t r;
    logic [1:0] op;
    int k, n;
    bit dispatched;
    logic [15:0] d;
    r = '0;
    op = beat[1:0];
    if (op == OP_APPEND) begin
      if (sh_count < SLOTS) begin
        sh_pid[sh_count]     = beat[9:2];
        sh_arrival[sh_count] = beat[25:10];
        sh_burst[sh_count]   = beat[41:26];
        sh_work[sh_count]    = '0;
        sh_slice[sh_count]   = sh_quantum;
        sh_status[sh_count]  = ST_WAIT;
        sh_mark[sh_count]    = 1'b0;
        sh_count++;
      end else begin
        r.table_full = 1'b1;
      end
    end else if (op == OP_CLEAR) begin
      sh_count = 0;
      sh_tick = '0;
    end else if (op == OP_TICK) begin
      k = -1;
      dispatched = 0;
      for (int i = 0; i < sh_count; i++)
        if (sh_status[i] == ST_WAIT && sh_arrival[i] == sh_tick) sh_status[i] = ST_READY;
      // first running entry: retire, continue or rotate out
      for (int i = 0; i < sh_count; i++) begin
        if (sh_status[i] != ST_RUN) continue;
        if (sh_work[i] >= sh_burst[i]) begin
          d = sh_tick - sh_arrival[i];
          sh_status[i] = ST_DONE;
          r.finish_valid = 1'b1;
          r.finish_pid = sh_pid[i];
          r.turnaround = d;
          r.waiting = (d > sh_burst[i]) ? d - sh_burst[i] : '0;
        end else if (sh_slice[i] > 0) begin
          sh_slice[i]--;
          if (sh_work[i] != 16'hFFFF) sh_work[i]++;
          k = i;
          dispatched = 1;
        end else begin
          sh_status[i] = ST_READY;
          sh_mark[i] = 1'b1;
          sh_slice[i] = sh_quantum;
        end
        break;
      end
      if (!dispatched) begin
        k = find_ready(1'b0);
        if (k < 0) begin
          k = find_ready(1'b1);
          for (int i = 0; i < sh_count; i++)
            if (sh_status[i] == ST_READY) sh_mark[i] = 1'b0;
        end
        if (k >= 0) begin
          sh_status[k] = ST_RUN;
          if (sh_work[k] != 16'hFFFF) sh_work[k]++;
          if (sh_slice[k] > 0) sh_slice[k]--;
        end
      end
      if (k >= 0) begin
        r.cpu_busy = 1'b1;
        r.running_pid = sh_pid[k];
      end
      sh_tick = sh_tick + 16'd1;
    end
    n = 0;
    for (int i = 0; i < sh_count; i++)
      if (sh_status[i] != ST_DONE) n++;
    r.unfinished_count = n[4:0];
    return r;
  endfunction

  // send one beat and queue its expected report; valid stays up until the next beat
  task automatic send_beat(logic [1:0] op, logic [7:0] pid, logic [15:0] arr,
                           logic [15:0] burst);
    logic [41:0] beat;
    beat = {burst, arr, pid, op};
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tuser <= beat[1:0];
    in_tdata <= beat[41:2];
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    report_queue.push_back(schedule_step(beat));
  endtask

  task automatic send_append(logic [7:0] pid, logic [15:0] arr, logic [15:0] burst);
    send_beat(OP_APPEND, pid, arr, burst);
  endtask

  task automatic send_tick();
    send_beat(OP_TICK, 8'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // wait until every expected report has arrived plus the block's latency
  task automatic drain();
    in_tvalid <= 1'b0;
    while (report_queue.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // write the quantum register while the block is idle
  task automatic write_quantum(logic [7:0] q);
    drain();
    cfg_data <= q;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sh_quantum = q;
    cfg_valid <= 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin
    sched_report_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (report_queue.size() == 0) begin
        $display("%0t: unexpected beat %h", $time, out_tdata);
        mismatch_count++;
      end else begin
        want = report_queue.pop_front();
        if (got !== want) begin
          $display("%0t: expected %h actual %h", $time, want, got);
          mismatch_count++;
        end
      end
    end
  end

  // receiver stalls
  always @(posedge clk)
    out_tready <= ($urandom_range(99) >= recv_idle_pct);

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // directed: extremes, every operation, refused append, unused code
  task automatic test_directed();
    send_beat(OP_UNUSED, 8'hFF, 16'hFFFF, 16'hFFFF);
    send_tick();
    send_beat(OP_CLEAR, 8'h00, 16'h0000, 16'h0000);
    send_append(8'h00, 16'd0, 16'd0);
    send_append(8'hFF, 16'd0, 16'd3);
    send_append(8'h55, 16'd2, 16'd1);
    send_append(8'hAA, 16'd1, 16'hFFFF);
    send_append(8'h11, 16'hFFFF, 16'd2);
    for (int i = 0; i < 11; i++) send_append(8'(i), 16'd3, 16'd1);
    send_append(8'h77, 16'd4, 16'd1);
    repeat (8) send_tick();
    send_beat(OP_CLEAR, 8'h00, 16'h0000, 16'h0000);
  endtask

  // random workloads: clear, append a batch, then mostly ticks with an occasional random operation
  task automatic test_workloads(int beats);
    int sent, n;
    sent = 0;
    while (sent < beats) begin
      send_beat(OP_CLEAR, 8'($urandom), 16'($urandom), 16'($urandom));
      n = $urandom_range(1, SLOTS);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(19) == 0)
          send_append(8'($urandom), 16'($urandom), 16'($urandom));
        else
          send_append(8'($urandom), 16'($urandom_range(0, 12)),
                      16'($urandom_range(0, 6)));
      end
      sent += n + 1;
      n = $urandom_range(10, 50);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(29) == 0)
          send_beat(2'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
        else send_tick();
      end
      sent += n;
    end
  endtask

  // pause the sender until every report is back, then continue
  task automatic test_pause();
    send_append(8'h42, 16'd0, 16'd2);
    send_tick();
    drain();
    send_tick();
    send_tick();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = 8'h00;
    in_tvalid = 1'b0;
    in_tuser = '0;
    in_tdata = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    sh_count = 0;
    sh_tick = '0;
    sh_quantum = QUANTUM_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 35;
    recv_idle_pct = 47;
    test_directed();
    write_quantum(8'd1);
    test_directed();
    test_workloads(170);
    write_quantum(8'd0);
    test_pause();

    send_idle_pct = 47;
    recv_idle_pct = 35;
    write_quantum(8'd255);
    test_workloads(100);
    write_quantum(8'd3);
    test_workloads(80);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_quantum(8'd2);
    test_workloads(150);
    drain();

    if (mismatch_count == 0 && report_queue.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/rrts_pkg.sv
rtl/round_robin_tick_scheduler.sv
tb/testbench.sv
